// ----- sv/cba_pkg.sv -----
// Shared constants, types and helper functions of the contiguous block allocator.
package cba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_W     = 16;
    localparam int WORDS      = MAX_BLOCKS / WORD_W;
    localparam int ADDR_W     = $clog2(WORDS);
    localparam int LANE_W     = $clog2(WORD_W);
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int POP_W      = $clog2(WORD_W + 1);
    localparam int FD_W       = 7;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BLK_W-1:0]  blk_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LANE_W-1:0] lane_t;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_MARK   = 2'd1,
        FUNC_CLR_CM = 2'd2,
        FUNC_CLR_TX = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_DEVICE  = 2'd0,
        REG_FIRST   = 2'd1,
        REG_RESERVE = 2'd2,
        REG_INPLACE = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MARK,
        ST_SET_RD,
        ST_SET_WR,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Result of scanning one bitmap word.
    typedef struct packed {
        logic [POP_W-1:0] pop;
        logic             hit;
        lane_t            hit_lane;
        cnt_t             run_out;
    } scan_res_t;

    // Ones from lane upward.
    function automatic word_t mask_from(input lane_t lane);
        mask_from = {WORD_W{1'b1}} << lane;
    endfunction

    // Ones from lane downward, lane included.
    function automatic word_t mask_upto(input lane_t lane);
        mask_upto = ~(({WORD_W{1'b1}} << lane) << 1);
    endfunction

endpackage

// ----- sv/cba_bitmap_ram.sv -----
// Simple dual-port bitmap RAM with registered read.
module cba_bitmap_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/cba_word_scan.sv -----
// Per-word free mask, free count and run search over one bitmap word.
module cba_word_scan import cba_pkg::*; (
    input  word_t     tx_word,
    input  word_t     cm_word,
    input  logic      tx_only,
    input  addr_t     word_idx,
    input  blk_t      start_blk,
    input  cnt_t      end_blk,
    input  cnt_t      run_in,
    input  blk_t      count,
    output scan_res_t res
);

    addr_t              start_w;
    lane_t              start_j;
    logic [ADDR_W:0]    end_w;
    lane_t              end_j;
    word_t              lo_mask;
    word_t              hi_mask;
    word_t              free;
    logic [POP_W-1:0]   zpos [WORD_W];
    cnt_t               run_lane [WORD_W];
    logic [WORD_W-1:0]  hit_vec;

    assign start_w = start_blk[BLK_W-1:LANE_W];
    assign start_j = start_blk[LANE_W-1:0];
    assign end_w   = end_blk[CNT_W-1:LANE_W];
    assign end_j   = end_blk[LANE_W-1:0];

    always_comb begin
        if (word_idx > start_w) begin
            lo_mask = '1;
        end else if (word_idx == start_w) begin
            lo_mask = mask_from(start_j);
        end else begin
            lo_mask = '0;
        end
        if ({1'b0, word_idx} < end_w) begin
            hi_mask = '1;
        end else if ({1'b0, word_idx} == end_w) begin
            hi_mask = ~mask_from(end_j);
        end else begin
            hi_mask = '0;
        end
    end

    assign free = ~tx_word & (tx_only ? {WORD_W{1'b1}} : ~cm_word) & lo_mask & hi_mask;

    // zpos: one past the highest non-free lane at or below j, 0 if none
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            zpos[j] = '0;
            for (int i = 0; i <= j; i++) begin
                if (!free[i]) begin
                    zpos[j] = POP_W'(i + 1);
                end
            end
            if (zpos[j] == '0) begin
                run_lane[j] = run_in + CNT_W'(j + 1);
            end else begin
                run_lane[j] = CNT_W'(j + 1) - CNT_W'(zpos[j]);
            end
            hit_vec[j] = free[j] && (run_lane[j] >= {1'b0, count});
        end
    end

    always_comb begin
        res.pop      = '0;
        res.hit      = 1'b0;
        res.hit_lane = '0;
        for (int j = 0; j < WORD_W; j++) begin
            res.pop = res.pop + POP_W'(free[j]);
        end
        // take the lowest lane that completes a run
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                res.hit      = 1'b1;
                res.hit_lane = lane_t'(j);
            end
        end
        res.run_out = run_lane[WORD_W-1];
    end

endmodule

// ----- sv/contiguous_block_allocator_core.sv -----
// Top level of the contiguous block allocator: control, config registers and bitmap RAMs.
//
//   channel | ports                                        | moves
//   --------+----------------------------------------------+------------------------------
//   s_      | s_valid/s_ready, s_func, s_count, ...        | one request beat
//   m_      | m_valid/m_ready, m_first_block, m_granted,.. | one result beat per request
//   apb     | psel/penable/pwrite/paddr/pwdata/prdata      | config register access
//
// Allocate: scans both maps one 16-bit word per cycle, then on a grant runs a
// read-modify-write over the run words of the transmit map before m_valid.
// Mark committed block: word read, then write. Clear of either map: a pass over all words.
// After reset a clearing pass over all WORDS (256) words zeroes both maps; s_ready stays low.
// The single read port of each bitmap RAM sets the scan rate; one request is in work at a time.
// A finished result waits in the output register; a new request is taken meanwhile.
module contiguous_block_allocator_core import cba_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [11:0]        s_count,
    input  logic [11:0]        s_block_index,
    input  logic               s_reserve_ok,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_first_block,
    output logic               m_granted,
    output logic [12:0]        m_free_count
);

    state_t          state_reg, state_next;
    logic [ADDR_W:0] addr_reg, addr_next;
    func_t           func_reg, func_next;
    blk_t            count_reg, count_next;
    blk_t            bidx_reg, bidx_next;
    logic            rok_reg, rok_next;
    cnt_t            free_reg, free_next;
    cnt_t            run_reg, run_next;
    logic            found_reg, found_next;
    blk_t            fblk_reg, fblk_next;
    logic            grant_reg, grant_next;
    logic            pipe_vld_reg;
    addr_t           pipe_idx_reg;

    logic            m_valid_reg, m_valid_next;
    blk_t            m_first_reg, m_first_next;
    logic            m_granted_reg, m_granted_next;
    cnt_t            m_free_reg, m_free_next;

    cnt_t              device_blocks_reg;
    logic [FD_W-1:0]   first_data_reg;
    cnt_t              reserve_reg;
    logic              tx_only_reg;

    logic      rd_en;
    addr_t     rd_addr;
    logic      cm_we, tx_we;
    addr_t     cm_waddr, tx_waddr;
    word_t     cm_wdata, tx_wdata;
    word_t     cm_rdata, tx_rdata;

    blk_t      start_blk;
    cnt_t      end_blk;
    scan_res_t scan;
    logic      sweep_last;
    logic      scan_last;
    logic      alloc_ok;
    cnt_t      spare;
    blk_t      lblk;
    addr_t     fw, lw;
    word_t     mark_mask;
    reg_idx_t  cfg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_blocks_reg <= CNT_W'(MAX_BLOCKS);
            first_data_reg    <= FD_W'(2);
            reserve_reg       <= CNT_W'(8);
            tx_only_reg       <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (cfg_idx)
                REG_DEVICE:  device_blocks_reg <= pwdata[CNT_W-1:0];
                REG_FIRST:   first_data_reg    <= pwdata[FD_W-1:0];
                REG_RESERVE: reserve_reg       <= pwdata[CNT_W-1:0];
                REG_INPLACE: tx_only_reg       <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEVICE:  prdata = PDATA_W'(device_blocks_reg);
            REG_FIRST:   prdata = PDATA_W'(first_data_reg);
            REG_RESERVE: prdata = PDATA_W'(reserve_reg);
            REG_INPLACE: prdata = PDATA_W'(tx_only_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- bitmap storage ----------------
    cba_bitmap_ram #(.DEPTH(WORDS), .WIDTH(WORD_W)) u_cm_ram (
        .aclk  (aclk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (cm_rdata)
    );

    cba_bitmap_ram #(.DEPTH(WORDS), .WIDTH(WORD_W)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (tx_rdata)
    );

    // ---------------- scan datapath ----------------
    assign start_blk = (first_data_reg == '0) ? BLK_W'(1) : BLK_W'(first_data_reg);
    assign end_blk   = (device_blocks_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                 : device_blocks_reg;

    cba_word_scan u_word_scan (
        .tx_word   (tx_rdata),
        .cm_word   (cm_rdata),
        .tx_only   (tx_only_reg),
        .word_idx  (pipe_idx_reg),
        .start_blk (start_blk),
        .end_blk   (end_blk),
        .run_in    (run_reg),
        .count     (count_reg),
        .res       (scan)
    );

    assign sweep_last = (addr_reg[ADDR_W-1:0] == ADDR_W'(WORDS - 1));
    assign scan_last  = pipe_vld_reg && (pipe_idx_reg == ADDR_W'(WORDS - 1));

    assign spare    = free_reg - {1'b0, count_reg};
    assign alloc_ok = (count_reg != '0) && (free_reg >= {1'b0, count_reg})
                      && (rok_reg || (spare >= reserve_reg));

    assign lblk = fblk_reg + count_reg - BLK_W'(1);
    assign fw   = fblk_reg[BLK_W-1:LANE_W];
    assign lw   = lblk[BLK_W-1:LANE_W];

    always_comb begin
        mark_mask = '1;
        if (pipe_idx_reg == fw) begin
            mark_mask = mark_mask & mask_from(fblk_reg[LANE_W-1:0]);
        end
        if (pipe_idx_reg == lw) begin
            mark_mask = mark_mask & mask_upto(lblk[LANE_W-1:0]);
        end
    end

    // ---------------- state machine: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (func_t'(s_func)) inside
                        FUNC_ALLOC:               state_next = ST_SCAN;
                        FUNC_MARK:                state_next = ST_SET_RD;
                        FUNC_CLR_CM, FUNC_CLR_TX: state_next = ST_CLEAR;
                        default:                  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_last) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = (alloc_ok && found_reg) ? ST_MARK : ST_DONE;
            end
            ST_MARK: begin
                if (pipe_vld_reg && (pipe_idx_reg == lw)) state_next = ST_DONE;
            end
            ST_SET_RD: state_next = ST_SET_WR;
            ST_SET_WR: state_next = ST_DONE;
            ST_CLEAR: begin
                if (sweep_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- state machine: memory control ----------------
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = addr_reg[ADDR_W-1:0];
        cm_we    = 1'b0;
        cm_waddr = addr_reg[ADDR_W-1:0];
        cm_wdata = '0;
        tx_we    = 1'b0;
        tx_waddr = addr_reg[ADDR_W-1:0];
        tx_wdata = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cm_we = 1'b1;
                tx_we = 1'b1;
            end
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: rd_en = !addr_reg[ADDR_W];
            ST_MARK: begin
                rd_en    = (addr_reg <= {1'b0, lw});
                tx_we    = pipe_vld_reg;
                tx_waddr = pipe_idx_reg;
                tx_wdata = tx_rdata | mark_mask;
            end
            ST_SET_RD: begin
                rd_en   = 1'b1;
                rd_addr = bidx_reg[BLK_W-1:LANE_W];
            end
            ST_SET_WR: begin
                cm_we    = 1'b1;
                cm_waddr = bidx_reg[BLK_W-1:LANE_W];
                cm_wdata = cm_rdata | (word_t'(1) << bidx_reg[LANE_W-1:0]);
            end
            ST_CLEAR: begin
                cm_we = (func_reg == FUNC_CLR_CM);
                tx_we = (func_reg == FUNC_CLR_TX);
            end
            default: ;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb begin
        addr_next      = addr_reg;
        func_next      = func_reg;
        count_next     = count_reg;
        bidx_next      = bidx_reg;
        rok_next       = rok_reg;
        free_next      = free_reg;
        run_next       = run_reg;
        found_next     = found_reg;
        fblk_next      = fblk_reg;
        grant_next     = grant_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_first_next   = m_first_reg;
        m_granted_next = m_granted_reg;
        m_free_next    = m_free_reg;
        unique case (state_reg) inside
            ST_INIT, ST_CLEAR: addr_next = addr_reg + 1'b1;
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = func_t'(s_func);
                    count_next = s_count;
                    bidx_next  = s_block_index;
                    rok_next   = s_reserve_ok;
                    addr_next  = '0;
                    free_next  = '0;
                    run_next   = '0;
                    found_next = 1'b0;
                    grant_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (rd_en) addr_next = addr_reg + 1'b1;
                if (pipe_vld_reg) begin
                    free_next = free_reg + CNT_W'(scan.pop);
                    run_next  = scan.run_out;
                    if (!found_reg && scan.hit) begin
                        found_next = 1'b1;
                        fblk_next  = {pipe_idx_reg, scan.hit_lane} + BLK_W'(1) - count_reg;
                    end
                end
            end
            ST_DECIDE: begin
                grant_next = alloc_ok && found_reg;
                addr_next  = {1'b0, fw};
            end
            ST_MARK: begin
                if (rd_en) addr_next = addr_reg + 1'b1;
            end
            ST_DONE: begin
                // load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = (func_reg == FUNC_ALLOC) && grant_reg;
                    m_first_next   = m_granted_next ? fblk_reg : '0;
                    m_free_next    = (func_reg == FUNC_ALLOC) ? free_reg : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            addr_reg     <= '0;
            found_reg    <= 1'b0;
            grant_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            func_reg     <= FUNC_ALLOC;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            found_reg    <= found_next;
            grant_reg    <= grant_next;
            pipe_vld_reg <= rd_en;
            m_valid_reg  <= m_valid_next;
            func_reg     <= func_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        bidx_reg      <= bidx_next;
        rok_reg       <= rok_next;
        free_reg      <= free_next;
        run_reg       <= run_next;
        fblk_reg      <= fblk_next;
        pipe_idx_reg  <= rd_addr;
        m_first_reg   <= m_first_next;
        m_granted_reg <= m_granted_next;
        m_free_reg    <= m_free_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_first_block = m_first_reg;
    assign m_granted     = m_granted_reg;
    assign m_free_count  = m_free_reg;

endmodule

// ----- sv/cba_checker.sv -----
// Port-level checker for the contiguous block allocator, bound to the top level.
module cba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_first_block,
    input logic        m_granted,
    input logic [12:0] m_free_count
);

    // clearing pass keeps the request side closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request accepted during clearing pass");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> m_first_block == 12'd0)
        else $error("failed result carries a block number");

    a_grant_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_first_block != 12'd0 && m_free_count != 13'd0)
        else $error("grant with block zero or no free blocks");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_block) && $stable(m_granted)
                                && $stable(m_free_count))
        else $error("result beat changed while stalled");

endmodule

bind contiguous_block_allocator_core cba_checker u_cba_checker (.*);
